[sv/framebuffer_dirty_rect_text_plotter_defines.svh]
// Assertion macros used by the framebuffer plotter controller.
// Depends on nothing; each user supplies clk and rst_n in its own scope.
`ifndef FRAMEBUFFER_DIRTY_RECT_TEXT_PLOTTER_DEFINES_SVH
`define FRAMEBUFFER_DIRTY_RECT_TEXT_PLOTTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FBDR_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fbdr: invariant violated");
`define FBDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbdr: sequence violated");
`else
`define FBDR_ASSERT_HOLDS(label, cond)
`define FBDR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/fbdr_pkg.sv]
// Shared types, constants and the 8x8 glyph ROM of the framebuffer plotter.
// Depends on nothing; used by fbdr_ctrl, fbdr_datapath and the top level.
package fbdr_pkg;

    // Frame geometry limits and store size.
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 768;
    localparam int GLYPH_COUNT = 128;
    localparam int ROM_CODES   = 1024 / 8;
    localparam int STORE_ROW   = (MAX_WIDTH + 3) / 4 * 4;
    localparam int STORE_SIZE  = STORE_ROW * MAX_HEIGHT;

    // Field and counter widths.
    localparam int W_W     = $clog2(MAX_WIDTH + 1);
    localparam int H_W     = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W  = $clog2(STORE_SIZE);
    localparam int LIM_W   = $clog2(STORE_SIZE + 1);
    localparam int XY_W    = 12;
    localparam int COLOR_W = 8;
    localparam int CODE_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int PIX_CNT_W  = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [W_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [H_W-1:0] HEIGHT_RESET = 10'd480;

    // Operation codes; the remaining codes are no-ops.
    typedef enum logic [2:0] {
        MODE_WRITE = 3'd0,
        MODE_READ  = 3'd1,
        MODE_CHAR  = 3'd2,
        MODE_FLUSH = 3'd3,
        MODE_CLEAR = 3'd4
    } mode_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PLOT,
        ST_DRAIN,
        ST_CLR_SETUP,
        ST_SWEEP,
        ST_RESULT,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic pix_issue;
        logic sweep_run;
        logic sweep_setup;
        logic res_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pix_last;
        logic sweep_last;
    } status_t;

    // Glyph ROM: one byte per glyph row, most significant bit at the left.
    localparam logic [7:0] GLYPH_ROM [8][ROM_CODES] = '{
        '{
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h08,8'h14,8'h14,8'h08,8'h00,8'h18,8'h08,
            8'h04,8'h10,8'h08,8'h08,8'h00,8'h00,8'h00,8'h01,
            8'h1C,8'h08,8'h1C,8'h1C,8'h0C,8'h3E,8'h1C,8'h3E,
            8'h1C,8'h1C,8'h00,8'h00,8'h04,8'h00,8'h20,8'h1C,
            8'h1C,8'h1C,8'h3C,8'h1C,8'h3C,8'h3E,8'h3E,8'h1C,
            8'h22,8'h1C,8'h0E,8'h22,8'h10,8'h41,8'h22,8'h1C,
            8'h1C,8'h1C,8'h3C,8'h1C,8'h3E,8'h22,8'h22,8'h41,
            8'h22,8'h22,8'h3E,8'h1C,8'h40,8'h1C,8'h08,8'h00,
            8'h10,8'h00,8'h10,8'h00,8'h02,8'h00,8'h0C,8'h00,
            8'h20,8'h00,8'h00,8'h20,8'h18,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h0C,8'h08,8'h30,8'h00,8'h00
        },
        '{
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h08,8'h14,8'h14,8'h1E,8'h32,8'h28,8'h08,
            8'h08,8'h08,8'h49,8'h08,8'h00,8'h00,8'h00,8'h02,
            8'h22,8'h18,8'h22,8'h22,8'h14,8'h20,8'h22,8'h02,
            8'h22,8'h22,8'h0C,8'h0C,8'h08,8'h00,8'h10,8'h22,
            8'h22,8'h22,8'h22,8'h22,8'h22,8'h20,8'h20,8'h22,
            8'h22,8'h08,8'h04,8'h22,8'h10,8'h63,8'h32,8'h22,
            8'h12,8'h22,8'h22,8'h22,8'h08,8'h22,8'h22,8'h41,
            8'h22,8'h22,8'h02,8'h10,8'h20,8'h04,8'h14,8'h00,
            8'h08,8'h1C,8'h10,8'h00,8'h02,8'h00,8'h12,8'h00,
            8'h20,8'h08,8'h08,8'h20,8'h08,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h08,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h10,8'h08,8'h08,8'h00,8'h00
        },
        '{
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h08,8'h00,8'h7F,8'h28,8'h34,8'h10,8'h00,
            8'h10,8'h04,8'h2A,8'h08,8'h00,8'h00,8'h00,8'h04,
            8'h22,8'h08,8'h02,8'h02,8'h24,8'h20,8'h20,8'h04,
            8'h22,8'h22,8'h0C,8'h0C,8'h10,8'h7F,8'h08,8'h02,
            8'h2E,8'h22,8'h22,8'h20,8'h22,8'h20,8'h20,8'h20,
            8'h22,8'h08,8'h04,8'h24,8'h10,8'h55,8'h2A,8'h22,
            8'h12,8'h22,8'h22,8'h20,8'h08,8'h22,8'h22,8'h41,
            8'h14,8'h14,8'h04,8'h10,8'h10,8'h04,8'h22,8'h00,
            8'h00,8'h02,8'h1C,8'h1C,8'h0E,8'h1C,8'h10,8'h1D,
            8'h2C,8'h00,8'h00,8'h24,8'h08,8'hB6,8'h2C,8'h1C,
            8'h2C,8'h1A,8'h2C,8'h1C,8'h1C,8'h24,8'h22,8'h41,
            8'h22,8'h12,8'h3C,8'h10,8'h08,8'h08,8'h30,8'h00
        },
        '{
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h08,8'h00,8'h14,8'h1C,8'h08,8'h28,8'h00,
            8'h10,8'h04,8'h1C,8'h7F,8'h00,8'h7F,8'h00,8'h08,
            8'h2A,8'h08,8'h04,8'h0C,8'h3E,8'h3C,8'h3C,8'h08,
            8'h1C,8'h1E,8'h00,8'h00,8'h20,8'h00,8'h04,8'h04,
            8'h2A,8'h3E,8'h3C,8'h20,8'h22,8'h3C,8'h3E,8'h2E,
            8'h3E,8'h08,8'h04,8'h38,8'h10,8'h49,8'h2A,8'h22,
            8'h1C,8'h22,8'h3C,8'h1C,8'h08,8'h22,8'h14,8'h2A,
            8'h08,8'h08,8'h08,8'h10,8'h08,8'h04,8'h00,8'h00,
            8'h00,8'h1E,8'h12,8'h20,8'h12,8'h22,8'h38,8'h22,
            8'h32,8'h08,8'h08,8'h28,8'h08,8'h49,8'h12,8'h22,
            8'h12,8'h24,8'h30,8'h20,8'h08,8'h24,8'h22,8'h41,
            8'h14,8'h12,8'h04,8'h20,8'h08,8'h04,8'h49,8'h00
        },
        '{
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h08,8'h00,8'h7F,8'h0A,8'h16,8'h46,8'h00,
            8'h10,8'h04,8'h2A,8'h08,8'h0C,8'h00,8'h00,8'h10,
            8'h22,8'h08,8'h08,8'h02,8'h04,8'h02,8'h22,8'h10,
            8'h22,8'h02,8'h0C,8'h0C,8'h10,8'h7F,8'h08,8'h08,
            8'h2E,8'h22,8'h22,8'h20,8'h22,8'h20,8'h20,8'h22,
            8'h22,8'h08,8'h24,8'h24,8'h10,8'h41,8'h26,8'h22,
            8'h10,8'h22,8'h28,8'h02,8'h08,8'h22,8'h14,8'h2A,
            8'h14,8'h08,8'h10,8'h10,8'h04,8'h04,8'h00,8'h00,
            8'h00,8'h22,8'h12,8'h20,8'h12,8'h3E,8'h10,8'h22,
            8'h22,8'h08,8'h08,8'h30,8'h08,8'h49,8'h12,8'h22,
            8'h12,8'h24,8'h20,8'h18,8'h08,8'h24,8'h22,8'h49,
            8'h08,8'h12,8'h08,8'h10,8'h08,8'h08,8'h06,8'h00
        },
        '{
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h14,8'h3C,8'h26,8'h44,8'h00,
            8'h08,8'h08,8'h49,8'h08,8'h0C,8'h00,8'h0C,8'h20,
            8'h22,8'h08,8'h10,8'h22,8'h04,8'h22,8'h22,8'h10,
            8'h22,8'h22,8'h0C,8'h0C,8'h08,8'h00,8'h10,8'h00,
            8'h20,8'h22,8'h22,8'h22,8'h22,8'h20,8'h20,8'h22,
            8'h22,8'h08,8'h24,8'h22,8'h10,8'h41,8'h22,8'h22,
            8'h10,8'h22,8'h24,8'h22,8'h08,8'h22,8'h08,8'h14,
            8'h22,8'h08,8'h20,8'h10,8'h02,8'h04,8'h00,8'h00,
            8'h00,8'h22,8'h12,8'h20,8'h12,8'h20,8'h10,8'h1E,
            8'h22,8'h08,8'h08,8'h28,8'h08,8'h41,8'h12,8'h22,
            8'h1C,8'h1C,8'h20,8'h04,8'h08,8'h24,8'h14,8'h55,
            8'h14,8'h0E,8'h10,8'h10,8'h08,8'h08,8'h00,8'h00
        },
        '{
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h08,8'h00,8'h14,8'h08,8'h00,8'h3A,8'h00,
            8'h04,8'h10,8'h08,8'h08,8'h04,8'h00,8'h0C,8'h40,
            8'h1C,8'h1C,8'h3E,8'h1C,8'h0E,8'h1C,8'h1C,8'h10,
            8'h1C,8'h1C,8'h00,8'h04,8'h04,8'h00,8'h20,8'h08,
            8'h1C,8'h22,8'h3C,8'h1C,8'h3C,8'h3E,8'h20,8'h1C,
            8'h22,8'h1C,8'h18,8'h22,8'h1E,8'h41,8'h22,8'h1C,
            8'h10,8'h1C,8'h22,8'h1C,8'h08,8'h1C,8'h08,8'h14,
            8'h22,8'h08,8'h3E,8'h1C,8'h01,8'h1C,8'h00,8'h00,
            8'h00,8'h1D,8'h2C,8'h1C,8'h0D,8'h1C,8'h10,8'h02,
            8'h22,8'h08,8'h08,8'h24,8'h08,8'h41,8'h12,8'h1C,
            8'h10,8'h04,8'h20,8'h38,8'h08,8'h1A,8'h08,8'h22,
            8'h22,8'h02,8'h3C,8'h0C,8'h08,8'h30,8'h00,8'h00
        },
        '{
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h08,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h08,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h06,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h7F,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1C,
            8'h00,8'h00,8'h30,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h10,8'h04,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h1C,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
        }
    };

    // One glyph row; codes without a glyph come back blank.
    function automatic logic [7:0] glyph_row(input logic [2:0] row,
                                             input logic [CODE_W-1:0] code);
        logic [7:0] bits;
        bits = 8'h00;
        if ((int'(code) < GLYPH_COUNT) && (int'(code) < ROM_CODES))
        begin
            bits = GLYPH_ROM[row][code[$clog2(ROM_CODES)-1:0]];
        end
        return bits;
    endfunction

endpackage

[sv/framebuffer_dirty_rect_text_plotter.sv]
// Top level of the indexed framebuffer with dirty rectangle and text plotter.
// Depends on fbdr_pkg, fbdr_ctrl and fbdr_datapath.
//
// Usage: a command is accepted on a rising edge with start high and busy low;
// mode selects write pixel, read pixel, draw character, flush or clear.
// Each command gives one result, shown for a single cycle with done high;
// the receiver cannot stall, so it must take the result in that cycle.
// A pixel write or read and a character draw (64 pixels, one access per
// pixel to the single-write-port store, which takes one byte per cycle,
// through a two-stage pixel pipeline) pass the plot and drain states; a
// clear zeroes R * H store bytes, R being the width rounded up to four and
// H the height, both clamped; flush and unused codes go to the result.
// busy drops in the cycle after done, so a new command may follow then.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; a transfer with index 0 sets the width, 1 the height, others
// are ignored. Write it only while busy is low.
// After reset the block runs a clearing pass over all 786432 store bytes,
// one per cycle, with busy high; configuration transfers are taken meanwhile.
module framebuffer_dirty_rect_text_plotter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic [2:0]                          mode,
    input  logic signed [fbdr_pkg::XY_W-1:0]    pos_x,
    input  logic signed [fbdr_pkg::XY_W-1:0]    pos_y,
    input  logic [fbdr_pkg::COLOR_W-1:0]        fore_color,
    input  logic [fbdr_pkg::COLOR_W-1:0]        back_color,
    input  logic [fbdr_pkg::CODE_W-1:0]         char_code,
    output logic [fbdr_pkg::COLOR_W-1:0]        read_value,
    output logic                                region_valid,
    output logic [fbdr_pkg::W_W-1:0]            region_left,
    output logic [fbdr_pkg::H_W-1:0]            region_top,
    output logic [fbdr_pkg::W_W-1:0]            region_right,
    output logic [fbdr_pkg::H_W-1:0]            region_bottom,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fbdr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fbdr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    fbdr_pkg::cmd_t    cmd;
    fbdr_pkg::status_t status;

    // Configuration writes complete in the cycle they are offered.
    assign cfg_ready = 1'b1;

    // Sequencing of each command.
    fbdr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Store, geometry, rectangle and result registers.
    fbdr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .fore_color    (fore_color),
        .back_color    (back_color),
        .char_code     (char_code),
        .read_value    (read_value),
        .region_valid  (region_valid),
        .region_left   (region_left),
        .region_top    (region_top),
        .region_right  (region_right),
        .region_bottom (region_bottom)
    );

endmodule

[sv/fbdr_ctrl.sv]
// Controller state machine of the framebuffer plotter.
// Depends on fbdr_pkg and the assertion macro header.
`include "framebuffer_dirty_rect_text_plotter_defines.svh"

module fbdr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2:0]            mode,
    input  fbdr_pkg::status_t     status,
    output fbdr_pkg::cmd_t        cmd,
    output logic                  busy,
    output logic                  done
);

    fbdr_pkg::state_t state_reg;
    fbdr_pkg::state_t state_next;

    // State register; reset starts the store clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbdr_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            fbdr_pkg::ST_INIT:
            begin
                cmd.sweep_run = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = fbdr_pkg::ST_IDLE;
                end
            end
            fbdr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    unique case (fbdr_pkg::mode_t'(mode))
                        fbdr_pkg::MODE_WRITE,
                        fbdr_pkg::MODE_READ,
                        fbdr_pkg::MODE_CHAR:  state_next = fbdr_pkg::ST_PLOT;
                        fbdr_pkg::MODE_CLEAR: state_next = fbdr_pkg::ST_CLR_SETUP;
                        default:              state_next = fbdr_pkg::ST_RESULT;
                    endcase
                end
            end
            fbdr_pkg::ST_PLOT:
            begin
                cmd.pix_issue = 1'b1;
                if (status.pix_last)
                begin
                    state_next = fbdr_pkg::ST_DRAIN;
                end
            end
            fbdr_pkg::ST_DRAIN:
            begin
                state_next = fbdr_pkg::ST_RESULT;
            end
            fbdr_pkg::ST_CLR_SETUP:
            begin
                cmd.sweep_setup = 1'b1;
                state_next      = fbdr_pkg::ST_SWEEP;
            end
            fbdr_pkg::ST_SWEEP:
            begin
                cmd.sweep_run = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = fbdr_pkg::ST_RESULT;
                end
            end
            fbdr_pkg::ST_RESULT:
            begin
                cmd.res_load = 1'b1;
                state_next   = fbdr_pkg::ST_DONE;
            end
            fbdr_pkg::ST_DONE:
            begin
                state_next = fbdr_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    assign busy = (state_reg != fbdr_pkg::ST_IDLE);
    assign done = (state_reg == fbdr_pkg::ST_DONE);

    // A character's pixels are issued back to back without a gap.
    `FBDR_ASSERT_NEXT(a_pix_run_unbroken, cmd.pix_issue && !status.pix_last, cmd.pix_issue)
    // Nothing touches the store while the block waits for work.
    `FBDR_ASSERT_HOLDS(a_idle_quiet, !busy |-> (!cmd.pix_issue && !cmd.sweep_run))
    // Loading the result is always followed by exactly one strobe cycle.
    `FBDR_ASSERT_NEXT(a_result_strobe, cmd.res_load, done && !cmd.res_load)

endmodule

[sv/fbdr_datapath.sv]
// Datapath of the framebuffer plotter: configuration, pixel pipeline, store,
// dirty rectangle, clearing sweep and result registers. Depends on fbdr_pkg.
module fbdr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fbdr_pkg::cmd_t                      cmd,
    output fbdr_pkg::status_t                   status,
    input  logic                                cfg_valid,
    input  logic [fbdr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fbdr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [2:0]                          mode,
    input  logic signed [fbdr_pkg::XY_W-1:0]    pos_x,
    input  logic signed [fbdr_pkg::XY_W-1:0]    pos_y,
    input  logic [fbdr_pkg::COLOR_W-1:0]        fore_color,
    input  logic [fbdr_pkg::COLOR_W-1:0]        back_color,
    input  logic [fbdr_pkg::CODE_W-1:0]         char_code,
    output logic [fbdr_pkg::COLOR_W-1:0]        read_value,
    output logic                                region_valid,
    output logic [fbdr_pkg::W_W-1:0]            region_left,
    output logic [fbdr_pkg::H_W-1:0]            region_top,
    output logic [fbdr_pkg::W_W-1:0]            region_right,
    output logic [fbdr_pkg::H_W-1:0]            region_bottom
);

    localparam int W_W    = fbdr_pkg::W_W;
    localparam int H_W    = fbdr_pkg::H_W;
    localparam int XY_W   = fbdr_pkg::XY_W;
    localparam int ADDR_W = fbdr_pkg::ADDR_W;
    localparam int LIM_W  = fbdr_pkg::LIM_W;
    localparam int CW     = fbdr_pkg::COLOR_W;
    localparam int PW     = W_W + H_W;

    // Configuration registers.
    logic [W_W-1:0] width_reg;
    logic [H_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= fbdr_pkg::WIDTH_RESET;
            height_reg <= fbdr_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == fbdr_pkg::CFG_WIDTH)
            begin
                width_reg <= cfg_data[W_W-1:0];
            end
            else if (cfg_index == fbdr_pkg::CFG_HEIGHT)
            begin
                height_reg <= cfg_data[H_W-1:0];
            end
        end
    end

    // Effective geometry: clamp to the store and pad rows to a multiple of four bytes.
    logic [W_W-1:0] w_eff;
    logic [H_W-1:0] h_eff;
    logic [W_W-1:0] w_plus3;
    logic [W_W-1:0] pitch;

    assign w_eff   = (width_reg > W_W'(fbdr_pkg::MAX_WIDTH)) ?
                     W_W'(fbdr_pkg::MAX_WIDTH) : width_reg;
    assign h_eff   = (height_reg > H_W'(fbdr_pkg::MAX_HEIGHT)) ?
                     H_W'(fbdr_pkg::MAX_HEIGHT) : height_reg;
    assign w_plus3 = w_eff + W_W'(3);
    assign pitch   = {w_plus3[W_W-1:2], 2'b00};

    // Item registers captured on the start transfer.
    fbdr_pkg::mode_t              mode_reg;
    logic signed [XY_W-1:0]       x_reg;
    logic signed [XY_W-1:0]       y_reg;
    logic [CW-1:0]                fg_reg;
    logic [CW-1:0]                bg_reg;
    logic [fbdr_pkg::CODE_W-1:0]  code_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= fbdr_pkg::mode_t'(mode);
            x_reg    <= pos_x;
            y_reg    <= pos_y;
            fg_reg   <= fore_color;
            bg_reg   <= back_color;
            code_reg <= char_code;
        end
    end

    // Pixel counter: column in the low three bits, glyph row above.
    logic [fbdr_pkg::PIX_CNT_W-1:0] pix_cnt_reg;
    logic                           is_char;

    assign is_char = (mode_reg == fbdr_pkg::MODE_CHAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_cnt_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            pix_cnt_reg <= '0;
        end
        else if (cmd.pix_issue)
        begin
            pix_cnt_reg <= pix_cnt_reg + 1'b1;
        end
    end

    assign status.pix_last = !is_char || (&pix_cnt_reg);

    // Stage A: pixel position, clip test, store address and color.
    logic [2:0]      col_off;
    logic [2:0]      row_off;
    logic [XY_W:0]   px;
    logic [XY_W:0]   py;
    logic            on_a;
    logic [H_W-1:0]  store_row;
    logic [PW-1:0]   addr_prod;
    logic [ADDR_W-1:0] addr_a;
    logic [7:0]      glyph_bits;
    logic [CW-1:0]   color_a;

    assign col_off    = is_char ? pix_cnt_reg[2:0] : 3'd0;
    assign row_off    = is_char ? pix_cnt_reg[5:3] : 3'd0;
    assign px         = {x_reg[XY_W-1], x_reg} + {{(XY_W-2){1'b0}}, col_off};
    assign py         = {y_reg[XY_W-1], y_reg} + {{(XY_W-2){1'b0}}, row_off};
    assign on_a       = !px[XY_W] && (px[XY_W-1:0] < XY_W'(w_eff)) &&
                        !py[XY_W] && (py[XY_W-1:0] < XY_W'(h_eff));
    assign store_row  = h_eff - H_W'(1) - py[H_W-1:0];
    assign addr_prod  = PW'(store_row) * PW'(pitch);
    assign addr_a     = addr_prod[ADDR_W-1:0] + ADDR_W'(px[W_W-2:0]);
    assign glyph_bits = fbdr_pkg::glyph_row(row_off, code_reg);
    assign color_a    = (!is_char || glyph_bits[3'd7 - col_off]) ? fg_reg : bg_reg;

    // Stage B registers.
    logic              valid_b_reg;
    logic              on_b_reg;
    logic [ADDR_W-1:0] addr_b_reg;
    logic [CW-1:0]     color_b_reg;
    logic [W_W-1:0]    px_b_reg;
    logic [H_W-1:0]    py_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_b_reg <= cmd.pix_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pix_issue)
        begin
            on_b_reg    <= on_a;
            addr_b_reg  <= addr_a;
            color_b_reg <= color_a;
            px_b_reg    <= px[W_W-1:0];
            py_b_reg    <= py[H_W-1:0];
        end
    end

    logic plot_we;
    assign plot_we = valid_b_reg && on_b_reg && (mode_reg != fbdr_pkg::MODE_READ);

    // Clearing sweep counter and its limit.
    logic [LIM_W-1:0] sweep_cnt_reg;
    logic [LIM_W-1:0] sweep_lim_reg;
    logic [PW-1:0]    clr_prod;
    logic [LIM_W:0]   sweep_cnt_inc;
    logic             sweep_we;

    assign clr_prod          = PW'(pitch) * PW'(h_eff);
    assign sweep_cnt_inc     = {1'b0, sweep_cnt_reg} + (LIM_W + 1)'(1);
    assign status.sweep_last = (sweep_cnt_inc >= {1'b0, sweep_lim_reg});
    assign sweep_we          = cmd.sweep_run && (sweep_cnt_reg < sweep_lim_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            sweep_lim_reg <= LIM_W'(fbdr_pkg::STORE_SIZE);
        end
        else
        begin
            if (cmd.sweep_setup)
            begin
                sweep_lim_reg <= clr_prod[LIM_W-1:0];
            end
            if (cmd.sweep_run)
            begin
                sweep_cnt_reg <= status.sweep_last ? '0 : sweep_cnt_inc[LIM_W-1:0];
            end
        end
    end

    // Frame store: one write port and one registered read port.
    logic [CW-1:0]     store_mem [fbdr_pkg::STORE_SIZE];
    logic [CW-1:0]     rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CW-1:0]     mem_wdata;

    assign mem_we    = sweep_we || plot_we;
    assign mem_waddr = sweep_we ? sweep_cnt_reg[ADDR_W-1:0] : addr_b_reg;
    assign mem_wdata = sweep_we ? '0 : color_b_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= store_mem[addr_b_reg];
    end

    // Dirty rectangle.
    logic           dirty_valid_reg;
    logic [W_W-1:0] dirty_left_reg;
    logic [H_W-1:0] dirty_top_reg;
    logic [W_W-1:0] dirty_right_reg;
    logic [H_W-1:0] dirty_bottom_reg;
    logic [W_W-1:0] px_b_end;
    logic [H_W-1:0] py_b_end;
    logic           flush_now;

    assign px_b_end  = px_b_reg + W_W'(1);
    assign py_b_end  = py_b_reg + H_W'(1);
    assign flush_now = cmd.res_load && (mode_reg == fbdr_pkg::MODE_FLUSH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_valid_reg  <= 1'b0;
            dirty_left_reg   <= '0;
            dirty_top_reg    <= '0;
            dirty_right_reg  <= '0;
            dirty_bottom_reg <= '0;
        end
        else if (cmd.sweep_setup)
        begin
            dirty_valid_reg  <= 1'b1;
            dirty_left_reg   <= '0;
            dirty_top_reg    <= '0;
            dirty_right_reg  <= w_eff;
            dirty_bottom_reg <= h_eff;
        end
        else if (flush_now)
        begin
            dirty_valid_reg  <= 1'b0;
            dirty_left_reg   <= '0;
            dirty_top_reg    <= '0;
            dirty_right_reg  <= '0;
            dirty_bottom_reg <= '0;
        end
        else if (plot_we)
        begin
            if (!dirty_valid_reg)
            begin
                dirty_valid_reg  <= 1'b1;
                dirty_left_reg   <= px_b_reg;
                dirty_top_reg    <= py_b_reg;
                dirty_right_reg  <= px_b_end;
                dirty_bottom_reg <= py_b_end;
            end
            else
            begin
                if (px_b_reg < dirty_left_reg)
                begin
                    dirty_left_reg <= px_b_reg;
                end
                if (px_b_end > dirty_right_reg)
                begin
                    dirty_right_reg <= px_b_end;
                end
                if (py_b_reg < dirty_top_reg)
                begin
                    dirty_top_reg <= py_b_reg;
                end
                if (py_b_end > dirty_bottom_reg)
                begin
                    dirty_bottom_reg <= py_b_end;
                end
            end
        end
    end

    // Result registers, loaded in the cycle before the done strobe.
    logic           report;
    assign report = flush_now && dirty_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            read_value    <= ((mode_reg == fbdr_pkg::MODE_READ) && on_b_reg) ?
                             rdata_reg : '0;
            region_valid  <= report;
            region_left   <= report ? dirty_left_reg   : '0;
            region_top    <= report ? dirty_top_reg    : '0;
            region_right  <= report ? dirty_right_reg  : '0;
            region_bottom <= report ? dirty_bottom_reg : '0;
        end
    end

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the framebuffer with dirty rectangle and text plotter.
// Depends on fbdr_pkg for geometry limits, mode and register codes and the glyph ROM.
// Directed cases come first, then random traffic over many frame geometries.
module tb_top;
    import fbdr_pkg::*;

    // Codes that the block treats as no-ops, and register indexes it ignores.
    localparam logic [2:0]           MODE_NOP_LO  = 3'd5;
    localparam logic [2:0]           MODE_NOP_HI  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Run sizing. Clears are only issued on frames that sweep quickly.
    localparam int RANDOM_ITEMS   = 1500;
    localparam int CLEAR_BUDGET   = 4096;
    localparam int WATCHDOG_LIMIT = 3_200_000;
    localparam int DRAIN_CYCLES   = 80;

    typedef struct {
        logic [2:0]                mode;
        logic signed [XY_W-1:0]    pos_x;
        logic signed [XY_W-1:0]    pos_y;
        logic [COLOR_W-1:0]        fore;
        logic [COLOR_W-1:0]        back;
        logic [CODE_W-1:0]         code;
    } fb_cmd_t;

    typedef struct {
        logic [COLOR_W-1:0] read_value;
        logic               region_valid;
        logic [W_W-1:0]     left;
        logic [H_W-1:0]     top;
        logic [W_W-1:0]     right;
        logic [H_W-1:0]     bottom;
    } fb_result_t;

    // Block ports.
    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      start         = 1'b0;
    logic                      busy;
    logic                      done;
    logic [2:0]                mode          = '0;
    logic signed [XY_W-1:0]    pos_x         = '0;
    logic signed [XY_W-1:0]    pos_y         = '0;
    logic [COLOR_W-1:0]        fore_color    = '0;
    logic [COLOR_W-1:0]        back_color    = '0;
    logic [CODE_W-1:0]         char_code     = '0;
    logic [COLOR_W-1:0]        read_value;
    logic                      region_valid;
    logic [W_W-1:0]            region_left;
    logic [H_W-1:0]            region_top;
    logic [W_W-1:0]            region_right;
    logic [H_W-1:0]            region_bottom;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index     = '0;
    logic [CFG_DATA_W-1:0]     cfg_data      = '0;

    // Shadow copy of the frame store, geometry registers and dirty box.
    bit   [7:0]     shadow_store [STORE_SIZE];
    logic [W_W-1:0] geo_width  = WIDTH_RESET;
    logic [H_W-1:0] geo_height = HEIGHT_RESET;
    bit             box_valid;
    int             box_left;
    int             box_top;
    int             box_right;
    int             box_bottom;

    // Results predicted for accepted commands, oldest first.
    fb_result_t awaited_results [$];

    // Bookkeeping.
    int  fail_count;
    int  results_seen;
    int  random_sent;
    int  geometry_count;
    int  mode_hits [8];
    int  stall_cycles;
    int  last_x;
    int  last_y;
    bit  steady_mode;

    framebuffer_dirty_rect_text_plotter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .done          (done),
        .mode          (mode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .fore_color    (fore_color),
        .back_color    (back_color),
        .char_code     (char_code),
        .read_value    (read_value),
        .region_valid  (region_valid),
        .region_left   (region_left),
        .region_top    (region_top),
        .region_right  (region_right),
        .region_bottom (region_bottom),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Geometry as the block uses it: registers clamped to the store limits.
    function automatic int active_width();
        return (int'(geo_width) > MAX_WIDTH) ? MAX_WIDTH : int'(geo_width);
    endfunction

    function automatic int active_height();
        return (int'(geo_height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(geo_height);
    endfunction

    function automatic int row_pitch();
        return (active_width() + 3) / 4 * 4;
    endfunction

    function automatic bit in_frame(int x, int y);
        return x >= 0 && x < active_width() && y >= 0 && y < active_height();
    endfunction

    // Rows are kept bottom-up in the store.
    function automatic int store_index(int x, int y);
        return (active_height() - 1 - y) * row_pitch() + x;
    endfunction

    // A clipped pixel write; only pixels that land grow the dirty box.
    function automatic void put_pixel(int x, int y, logic [7:0] color);
        if (!in_frame(x, y))
            return;
        shadow_store[store_index(x, y)] = color;
        if (!box_valid)
        begin
            box_valid  = 1'b1;
            box_left   = x;
            box_top    = y;
            box_right  = x + 1;
            box_bottom = y + 1;
        end
        else
        begin
            if (x < box_left)
                box_left = x;
            if (x + 1 > box_right)
                box_right = x + 1;
            if (y < box_top)
                box_top = y;
            if (y + 1 > box_bottom)
                box_bottom = y + 1;
        end
    endfunction

    // Applies one command to the shadow state and returns the result it gives.
    function automatic fb_result_t apply_command(fb_cmd_t c);
        fb_result_t r;
        int         x0;
        int         y0;
        int         n;
        logic [7:0] bits;
        r.read_value   = '0;
        r.region_valid = 1'b0;
        r.left         = '0;
        r.top          = '0;
        r.right        = '0;
        r.bottom       = '0;
        x0 = c.pos_x;
        y0 = c.pos_y;
        case (c.mode)
            MODE_WRITE:
                put_pixel(x0, y0, c.fore);
            MODE_READ:
                if (in_frame(x0, y0))
                    r.read_value = shadow_store[store_index(x0, y0)];
            MODE_CHAR:
                for (int row = 0; row < 8; row++)
                begin
                    bits = 8'h00;
                    if (c.code < GLYPH_COUNT && c.code < ROM_CODES)
                        bits = GLYPH_ROM[row][c.code[6:0]];
                    for (int col = 0; col < 8; col++)
                        put_pixel(x0 + col, y0 + row, bits[7 - col] ? c.fore : c.back);
                end
            MODE_FLUSH:
                if (box_valid)
                begin
                    r.region_valid = 1'b1;
                    r.left         = box_left[W_W-1:0];
                    r.top          = box_top[H_W-1:0];
                    r.right        = box_right[W_W-1:0];
                    r.bottom       = box_bottom[H_W-1:0];
                    box_valid      = 1'b0;
                    box_left       = 0;
                    box_top        = 0;
                    box_right      = 0;
                    box_bottom     = 0;
                end
            MODE_CLEAR:
            begin
                n = row_pitch() * active_height();
                for (int i = 0; i < n; i++)
                    shadow_store[i] = 8'h00;
                box_valid  = 1'b1;
                box_left   = 0;
                box_top    = 0;
                box_right  = active_width();
                box_bottom = active_height();
            end
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic fb_cmd_t cmd_of(logic [2:0] m, int x, int y, int fg, int bg, int code);
        fb_cmd_t c;
        c.mode  = m;
        c.pos_x = x[XY_W-1:0];
        c.pos_y = y[XY_W-1:0];
        c.fore  = fg[COLOR_W-1:0];
        c.back  = bg[COLOR_W-1:0];
        c.code  = code[CODE_W-1:0];
        return c;
    endfunction

    // Idle cycles before a transfer: none in a steady phase, else short gaps
    // with an occasional long one that can span a whole character draw.
    function automatic int pick_gap();
        if (steady_mode || $urandom_range(0, 99) >= 29)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(8, 90);
        return $urandom_range(1, 4);
    endfunction

    // A coordinate mostly near the frame, sometimes on its edges, sometimes anywhere.
    function automatic int pick_coord(int extent);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return $urandom_range(0, 3071) - 1024;
        if (r < 25)
        begin
            case ($urandom_range(0, 3))
                0:       return -1;
                1:       return 0;
                2:       return extent - 1;
                default: return extent;
            endcase
        end
        return $urandom_range(0, extent + 15) - 8;
    endfunction

    // Sends one command and records its predicted result once it is taken.
    task automatic send_command(input fb_cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= c.mode;
        pos_x      <= c.pos_x;
        pos_y      <= c.pos_y;
        fore_color <= c.fore;
        back_color <= c.back;
        char_code  <= c.code;
        do
            @(posedge clk);
        while (busy);
        awaited_results.push_back(apply_command(c));
        mode_hits[c.mode]++;
    endtask

    // One transfer on the configuration channel; valid is left high.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_WIDTH)
            geo_width = value[W_W-1:0];
        else if (idx == CFG_HEIGHT)
            geo_height = value[H_W-1:0];
    endtask

    // Waits until the block is idle, then sets a new geometry. An ignored
    // index is written in between to show it changes nothing.
    task automatic set_geometry(input int w, input int h);
        start <= 1'b0;
        while (busy || awaited_results.size() != 0)
            @(posedge clk);
        write_register(CFG_WIDTH, w);
        write_register(geometry_count[0] ? CFG_SPARE_HI : CFG_SPARE_LO,
                       $urandom_range(0, 2047));
        write_register(CFG_HEIGHT, h);
        cfg_valid <= 1'b0;
        geometry_count++;
    endtask

    // Reset geometry: clipping at the left, right and bottom sides and a first flush.
    task automatic test_reset_defaults();
        send_command(cmd_of(MODE_READ, 0, 0, 0, 0, 0));
        send_command(cmd_of(MODE_WRITE, 639, 479, 8'hFF, 0, 0));
        send_command(cmd_of(MODE_WRITE, 640, 0, 8'h11, 0, 0));
        send_command(cmd_of(MODE_WRITE, -1024, 2047, 8'h22, 0, 0));
        send_command(cmd_of(MODE_WRITE, 0, 480, 8'h33, 0, 0));
        send_command(cmd_of(MODE_READ, 639, 479, 0, 0, 0));
        send_command(cmd_of(MODE_FLUSH, 0, 0, 0, 0, 0));
        send_command(cmd_of(MODE_FLUSH, 0, 0, 0, 0, 0));
    endtask

    // Characters partly off the frame, codes without a glyph, a no-op code, clear.
    task automatic test_character_draw();
        set_geometry(20, 12);
        send_command(cmd_of(MODE_CHAR, -3, -2, 8'hAA, 8'h55, 8'h41));
        send_command(cmd_of(MODE_CHAR, 14, 8, 8'h0F, 8'hF0, 8'h80));
        send_command(cmd_of(MODE_CHAR, 4, 2, 8'hC3, 8'h3C, 8'hFF));
        send_command(cmd_of(MODE_READ, 1, 1, 0, 0, 0));
        send_command(cmd_of(MODE_FLUSH, 0, 0, 0, 0, 0));
        send_command(cmd_of(MODE_NOP_HI, 2047, -1, 8'hFF, 8'hFF, 8'hFF));
        send_command(cmd_of(MODE_CLEAR, 0, 0, 0, 0, 0));
        send_command(cmd_of(MODE_FLUSH, 0, 0, 0, 0, 0));
    endtask

    // Zero, clamped and exact-limit registers.
    task automatic test_register_extremes();
        set_geometry(0, 0);
        send_command(cmd_of(MODE_CLEAR, 0, 0, 0, 0, 0));
        send_command(cmd_of(MODE_WRITE, 0, 0, 8'h77, 0, 0));
        send_command(cmd_of(MODE_FLUSH, 0, 0, 0, 0, 0));
        set_geometry(2047, 1);
        send_command(cmd_of(MODE_CLEAR, 0, 0, 0, 0, 0));
        send_command(cmd_of(MODE_WRITE, 1023, 0, 8'h5A, 0, 0));
        send_command(cmd_of(MODE_FLUSH, 0, 0, 0, 0, 0));
        set_geometry(1, 1023);
        send_command(cmd_of(MODE_CLEAR, 0, 0, 0, 0, 0));
        send_command(cmd_of(MODE_WRITE, 0, 767, 8'hC3, 0, 0));
        set_geometry(1024, 768);
        send_command(cmd_of(MODE_READ, 1023, 767, 0, 0, 0));
        send_command(cmd_of(MODE_CHAR, 1020, 764, 8'h01, 8'hFE, 8'h57));
        send_command(cmd_of(MODE_FLUSH, 0, 0, 0, 0, 0));
    endtask

    // One random command shaped by the current geometry.
    task automatic random_command();
        fb_cmd_t c;
        int      r;
        int      aw;
        int      ah;
        int      x;
        int      y;
        aw = active_width();
        ah = active_height();
        r  = $urandom_range(0, 99);
        x  = pick_coord(aw);
        y  = pick_coord(ah);
        c  = cmd_of(MODE_FLUSH, x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(128, 255)
                                                : $urandom_range(0, 127));
        if (r < 28)
        begin
            c.mode = MODE_WRITE;
            if (in_frame(x, y))
            begin
                last_x = x;
                last_y = y;
            end
        end
        else if (r < 55)
        begin
            // Half of the reads look back near the last pixel that landed.
            c.mode = MODE_READ;
            if ($urandom_range(0, 1) == 0)
            begin
                c.pos_x = last_x + $urandom_range(0, 6) - 3;
                c.pos_y = last_y + $urandom_range(0, 6) - 3;
            end
        end
        else if (r < 80)
            c.mode = MODE_CHAR;
        else if (r < 95 && r >= 90 && row_pitch() * ah <= CLEAR_BUDGET)
            c.mode = MODE_CLEAR;
        else if (r >= 95)
            c.mode = $urandom_range(MODE_NOP_LO, MODE_NOP_HI);
        send_command(c);
        random_sent++;
    endtask

    // Phases of random traffic, each under a fresh geometry.
    task automatic test_random_traffic();
        int phase;
        int w;
        int h;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    case ($urandom_range(0, 3))
                        0:       w = 0;
                        1:       w = 1;
                        2:       w = MAX_WIDTH;
                        default: w = 2047;
                    endcase
                    case ($urandom_range(0, 3))
                        0:       h = 0;
                        1:       h = 1;
                        2:       h = MAX_HEIGHT;
                        default: h = 1023;
                    endcase
                end
                1:
                begin
                    w = $urandom_range(0, 2047);
                    h = $urandom_range(0, 1023);
                end
                default:
                begin
                    w = $urandom_range(1, 48);
                    h = $urandom_range(1, 40);
                end
            endcase
            steady_mode = 1'b0;
            set_geometry(w, h);
            steady_mode = (phase == 3);
            repeat ($urandom_range(40, 120)) random_command();
            phase++;
        end
        steady_mode = 1'b0;
    endtask

    // Each result is taken in its done cycle and compared with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        fb_result_t e;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with no command awaiting it");
                fail_count++;
            end
            else
            begin
                e = awaited_results.pop_front();
                results_seen++;
                if (read_value !== e.read_value)
                begin
                    $error("read_value: expected %0d, actual %0d", e.read_value, read_value);
                    fail_count++;
                end
                if (region_valid !== e.region_valid)
                begin
                    $error("region_valid: expected %0d, actual %0d",
                           e.region_valid, region_valid);
                    fail_count++;
                end
                if (region_left !== e.left)
                begin
                    $error("region_left: expected %0d, actual %0d", e.left, region_left);
                    fail_count++;
                end
                if (region_top !== e.top)
                begin
                    $error("region_top: expected %0d, actual %0d", e.top, region_top);
                    fail_count++;
                end
                if (region_right !== e.right)
                begin
                    $error("region_right: expected %0d, actual %0d", e.right, region_right);
                    fail_count++;
                end
                if (region_bottom !== e.bottom)
                begin
                    $error("region_bottom: expected %0d, actual %0d",
                           e.bottom, region_bottom);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run after too long without any transfer.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Test sequence.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_character_draw();
        test_register_extremes();
        test_random_traffic();
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d pixel writes, %0d reads, %0d characters, %0d flushes, %0d clears",
                 mode_hits[MODE_WRITE], mode_hits[MODE_READ], mode_hits[MODE_CHAR],
                 mode_hits[MODE_FLUSH], mode_hits[MODE_CLEAR]);
        $display("and %0d no-op codes over %0d geometries; %0d results compared.",
                 mode_hits[5] + mode_hits[6] + mode_hits[7], geometry_count, results_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
